// ===== sv/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

   localparam int ElemW   = 32;
   localparam int NumW    = 96;   // |adjugate| scaled by 2^32
   localparam int DetW    = 99;   // signed determinant, 48 fraction bits
   localparam int ThrW    = 63;
   localparam int QuoW    = 33;   // quotient bits kept before saturation
   localparam int DivStg  = 34;   // overflow check plus one stage per quotient bit
   localparam int PipeStg = 40;   // total register stages, input to result

   localparam logic [ThrW-1:0]  ThrReset = 63'd2814750;
   localparam logic [ElemW-1:0] SatPos   = 32'h7FFF_FFFF;
   localparam logic [ElemW-1:0] SatNeg   = 32'h8000_0000;

   // Adjugate element k = m[CofA]*m[CofB] - m[CofC]*m[CofD], elements in row-major order
   localparam logic [3:0] CofA [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
   localparam logic [3:0] CofB [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
   localparam logic [3:0] CofC [9] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd4, 4'd0, 4'd3};
   localparam logic [3:0] CofD [9] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd6, 4'd7, 4'd1};

   // One divider lane's operands and flags
   typedef struct packed {
      logic [NumW-1:0]  num;
      logic [DetW-1:0]  den;
      logic             neg;
      logic             nz;
      logic             sing;
      logic [ElemW-1:0] echo;
   } lane_type;

endpackage
`default_nettype wire

// ===== sv/mi3_lane.sv =====
// One pipelined restoring divider lane with saturation and singular echo.
`timescale 1ns / 1ps
`default_nettype none
module mi3_lane (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire mi3_pkg::lane_type          lane_in,
   output logic [mi3_pkg::ElemW-1:0]       res
);

   localparam int RW = mi3_pkg::DetW + mi3_pkg::QuoW;   // shifted divisor width

   typedef struct packed {
      logic [mi3_pkg::NumW-1:0]  r;
      logic [mi3_pkg::DetW-1:0]  d;
      logic [mi3_pkg::QuoW-1:0]  q;
      logic                      ovf;
      logic                      neg;
      logic                      nz;
      logic                      sing;
      logic [mi3_pkg::ElemW-1:0] echo;
   } stage_type;

   stage_type st_ff [mi3_pkg::DivStg];
   stage_type st_in [mi3_pkg::DivStg];
   logic [mi3_pkg::ElemW-1:0] res_ff, res_in;

   // Check overflow first, then retire one quotient bit per stage
   always_comb begin
      logic [RW-1:0] dsh;
      st_in[0].r    = lane_in.num;
      st_in[0].d    = lane_in.den;
      st_in[0].q    = '0;
      st_in[0].neg  = lane_in.neg;
      st_in[0].nz   = lane_in.nz;
      st_in[0].sing = lane_in.sing;
      st_in[0].echo = lane_in.echo;
      st_in[0].ovf  = RW'(lane_in.num) >= {lane_in.den, {mi3_pkg::QuoW{1'b0}}};
      for (int j = 1; j < mi3_pkg::DivStg; j++) begin
         st_in[j] = st_ff[j-1];
         dsh = RW'(st_ff[j-1].d) << (mi3_pkg::DivStg - 1 - j);
         if (!st_ff[j-1].ovf && (RW'(st_ff[j-1].r) >= dsh)) begin
            st_in[j].r = st_ff[j-1].r - dsh[mi3_pkg::NumW-1:0];
            st_in[j].q[mi3_pkg::DivStg-1-j] = 1'b1;
         end
      end
   end

   // Apply sign, saturate, give zero for a zero adjugate element, or echo the input element
   always_comb begin
      stage_type f;
      f = st_ff[mi3_pkg::DivStg-1];
      if (f.sing) begin
         res_in = f.echo;
      end else if (!f.nz) begin
         res_in = '0;
      end else if (f.neg) begin
         if (f.ovf || f.q > mi3_pkg::QuoW'(mi3_pkg::SatNeg)) begin
            res_in = mi3_pkg::SatNeg;
         end else begin
            res_in = ~f.q[mi3_pkg::ElemW-1:0] + 1'b1;
         end
      end else begin
         if (f.ovf || f.q > mi3_pkg::QuoW'(mi3_pkg::SatPos)) begin
            res_in = mi3_pkg::SatPos;
         end else begin
            res_in = f.q[mi3_pkg::ElemW-1:0];
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < mi3_pkg::DivStg; j++) begin
            st_ff[j] <= st_in[j];
         end
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// ===== sv/matrix3_inverse.sv =====
// Top level of the streaming 3x3 matrix inverse by the adjugate.
// Usage:
//   req channel: one 3x3 Q16.16 matrix per transfer on req_tdata.
//   rsp channel: the Q16.16 inverse on rsp_tdata, rsp_tuser set when
//     |det| fell below the threshold and the input was echoed instead.
//   csr channel: writes the 63-bit determinant threshold (units of 2^-48);
//     write only while no matrix is in flight.
// From req transfer to rsp_tvalid, two stages form the cofactors, two
// the determinant, one the magnitude and threshold compare, 34 the
// per-element divider (overflow check and one quotient bit each), one
// the saturation. A matrix can enter every cycle unless the output stalls.
// The whole pipeline advances as one: when rsp_tvalid is high and
// rsp_tready low, every stage holds and req_tready drops; nothing is
// lost or repeated. Reset empties the pipeline and restores the
// threshold to its default.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [9*mi3_pkg::ElemW-1:0] req_tdata,  // m11,m12,m13,m21,..,m33 from bit 0
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [9*mi3_pkg::ElemW-1:0]      rsp_tdata,  // r11,r12,r13,r21,..,r33 from bit 0
   output logic [0:0]                       rsp_tuser,  // singular
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [mi3_pkg::ThrW-1:0]    csr_data
);

   localparam int EW = mi3_pkg::ElemW;
   localparam int DW = mi3_pkg::DetW;

   logic en;
   logic [mi3_pkg::PipeStg-1:0] v_ff;
   logic [mi3_pkg::ThrW-1:0] thr_ff;

   logic signed [EW-1:0]   m_w     [9];
   logic signed [2*EW-1:0] pa_ff   [9];
   logic signed [2*EW-1:0] pc_ff   [9];
   logic signed [EW-1:0]   ma_ff   [9];
   logic signed [2*EW:0]   adjb_ff [9];
   logic signed [EW-1:0]   mb_ff   [9];
   logic signed [2*EW:0]   adjc_ff [9];
   logic signed [EW-1:0]   mc_ff   [9];
   logic signed [2*EW:0]   plo_ff  [3];
   logic signed [2*EW:0]   phi_ff  [3];
   logic signed [2*EW:0]   adjd_ff [9];
   logic signed [EW-1:0]   md_ff   [9];
   logic signed [DW-1:0]   det_ff;
   mi3_pkg::lane_type      lane_ff [9];
   logic [EW-1:0]          res_w   [9];

   // Advance when the result slot is empty or being taken
   assign en         = !v_ff[mi3_pkg::PipeStg-1] || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = v_ff[mi3_pkg::PipeStg-1];

   // Hold the threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mi3_pkg::ThrReset;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // Shift valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[mi3_pkg::PipeStg-2:0], req_tvalid};
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         m_w[k] = req_tdata[k*EW +: EW];
      end
   end

   // Form the cofactor products, then the cofactors, then det partials and the determinant
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            pa_ff[k]   <= m_w[mi3_pkg::CofA[k]] * m_w[mi3_pkg::CofB[k]];
            pc_ff[k]   <= m_w[mi3_pkg::CofC[k]] * m_w[mi3_pkg::CofD[k]];
            ma_ff[k]   <= m_w[k];
            adjb_ff[k] <= (2*EW+1)'(pa_ff[k]) - (2*EW+1)'(pc_ff[k]);
            mb_ff[k]   <= ma_ff[k];
            adjc_ff[k] <= adjb_ff[k];
            mc_ff[k]   <= mb_ff[k];
            adjd_ff[k] <= adjc_ff[k];
            md_ff[k]   <= mc_ff[k];
         end
         for (int t = 0; t < 3; t++) begin
            plo_ff[t] <= $signed({1'b0, adjb_ff[3*t][EW-1:0]}) * mb_ff[t];
            phi_ff[t] <= $signed(adjb_ff[3*t][2*EW:EW]) * mb_ff[t];
         end
         det_ff <= ((DW'(phi_ff[0]) <<< EW) + DW'(plo_ff[0]))
                 + ((DW'(phi_ff[1]) <<< EW) + DW'(plo_ff[1]))
                 + ((DW'(phi_ff[2]) <<< EW) + DW'(plo_ff[2]));
      end
   end

   // Take magnitudes and signs, compare against the threshold
   always_ff @(posedge clock) begin
      logic [DW-1:0]   mag;
      logic [2*EW:0]   aa;
      logic            sing;
      if (en) begin
         mag  = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         sing = mag < DW'(thr_ff);
         for (int k = 0; k < 9; k++) begin
            aa = adjd_ff[k][2*EW] ? (2*EW+1)'(-adjd_ff[k]) : (2*EW+1)'(adjd_ff[k]);
            lane_ff[k].num  <= {aa[2*EW-1:0], {EW{1'b0}}};
            lane_ff[k].den  <= mag;
            lane_ff[k].neg  <= adjd_ff[k][2*EW] ^ det_ff[DW-1];
            lane_ff[k].nz   <= adjd_ff[k] != '0;
            lane_ff[k].sing <= sing;
            lane_ff[k].echo <= md_ff[k];
         end
      end
   end

   // Nine divider lanes, one per inverse element
   for (genvar g = 0; g < 9; g++) begin : g_lane
      mi3_lane u_lane (
         .clock   (clock),
         .en      (en),
         .lane_in (lane_ff[g]),
         .res     (res_w[g])
      );
      assign rsp_tdata[g*EW +: EW] = res_w[g];
   end

   // Carry the singular flag from lane zero; all lanes share it
   logic sing_q_ff [mi3_pkg::DivStg+1];
   always_ff @(posedge clock) begin
      if (en) begin
         sing_q_ff[0] <= lane_ff[0].sing;
         for (int j = 1; j <= mi3_pkg::DivStg; j++) begin
            sing_q_ff[j] <= sing_q_ff[j-1];
         end
      end
   end
   assign rsp_tuser[0] = sing_q_ff[mi3_pkg::DivStg];

endmodule
`default_nettype wire
